[design/ipv4fd_pkg.sv]
package ipv4fd_pkg;

   // Route table depth default
   localparam int ROUTE_ENTRIES_DEFAULT = 64;

   // Field widths
   localparam int ADDR_W      = 32;
   localparam int HOP_W       = 32;
   localparam int WORD_W      = 16;
   localparam int TTL_W       = 8;
   localparam int IHL_W       = 4;
   localparam int WORD_IDX_W  = 5;
   localparam int SUM_W       = 21;
   localparam int VERDICT_W   = 3;

   // Command codes
   localparam logic CMD_ADD_ROUTE   = 1'b0;
   localparam logic CMD_HEADER_WORD = 1'b1;

   // Header word positions of interest
   localparam logic [WORD_IDX_W-1:0] WORD_IHL      = 5'd0;
   localparam logic [WORD_IDX_W-1:0] WORD_TTL      = 5'd4;
   localparam logic [WORD_IDX_W-1:0] WORD_CHECKSUM = 5'd5;
   localparam logic [WORD_IDX_W-1:0] WORD_DEST_HI  = 5'd8;
   localparam logic [WORD_IDX_W-1:0] WORD_DEST_LO  = 5'd9;

   // Shortest legal header length in 32-bit words
   localparam logic [IHL_W-1:0] MIN_IHL = 4'd5;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_LOCAL    = 3'd0,
      VERDICT_FORWARD  = 3'd1,
      VERDICT_NO_ROUTE = 3'd2,
      VERDICT_TTL_ZERO = 3'd3,
      VERDICT_ADDED    = 3'd4,
      VERDICT_FULL     = 3'd5
   } verdict_type;

   // Header parser status toward the decision stage
   typedef struct packed {
      logic              last;
      logic [ADDR_W-1:0] dest;
      logic [TTL_W-1:0]  ttl;
      logic [SUM_W-1:0]  sum;
   } hdr_status_type;

   // Route addition request into the table
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] dest;
      logic [HOP_W-1:0]  hop;
   } route_add_type;

endpackage

[design/ipv4fd_header_parser.sv]
module ipv4fd_header_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                word_en,
   input  logic [ipv4fd_pkg::WORD_W-1:0]       word,
   output ipv4fd_pkg::hdr_status_type          status
);

   logic [ipv4fd_pkg::WORD_IDX_W-1:0] word_index_ff, word_index_in;
   logic [ipv4fd_pkg::IHL_W-1:0]      header_words_ff, header_words_in;
   logic [ipv4fd_pkg::TTL_W-1:0]      held_ttl_ff, held_ttl_in;
   logic [ipv4fd_pkg::ADDR_W-1:0]     held_dest_ff, held_dest_in;
   logic [ipv4fd_pkg::SUM_W-1:0]      running_sum_ff, running_sum_in;

   logic [ipv4fd_pkg::SUM_W-1:0]      sum_base;
   logic [ipv4fd_pkg::SUM_W-1:0]      sum_new;
   logic [ipv4fd_pkg::WORD_W-1:0]     addend;
   logic [ipv4fd_pkg::IHL_W-1:0]      ihl;
   logic [ipv4fd_pkg::WORD_IDX_W-1:0] last_idx;

   // Count words, capture fields and accumulate the checksum
   always_comb begin
      word_index_in   = word_index_ff;
      header_words_in = header_words_ff;
      held_ttl_in     = held_ttl_ff;
      held_dest_in    = held_dest_ff;
      running_sum_in  = running_sum_ff;
      ihl             = word[11:8];
      sum_base        = running_sum_ff;
      addend          = word;
      sum_new         = '0;
      last_idx        = '0;
      status          = '0;
      if (word_en) begin
         // First word: latch length, restart the sum
         if (word_index_ff == ipv4fd_pkg::WORD_IHL) begin
            header_words_in = (ihl < ipv4fd_pkg::MIN_IHL) ? ipv4fd_pkg::MIN_IHL : ihl;
            sum_base        = '0;
         end
         case (word_index_ff)
            ipv4fd_pkg::WORD_TTL: begin
               held_ttl_in = word[15:8];
               addend      = {word[15:8] - 8'd1, word[7:0]};
            end
            ipv4fd_pkg::WORD_CHECKSUM: begin
               addend = '0;
            end
            ipv4fd_pkg::WORD_DEST_HI: begin
               held_dest_in[31:16] = word;
            end
            ipv4fd_pkg::WORD_DEST_LO: begin
               held_dest_in[15:0] = word;
            end
            default: ;
         endcase
         sum_new        = sum_base + ipv4fd_pkg::SUM_W'(addend);
         running_sum_in = sum_new;
         last_idx       = {header_words_in, 1'b0} - 5'd1;
         if (word_index_ff < last_idx) begin
            word_index_in = word_index_ff + 5'd1;
         end else begin
            // Last word: hand off and restart
            word_index_in  = '0;
            running_sum_in = '0;
            status.last    = 1'b1;
         end
         status.dest = held_dest_in;
         status.ttl  = held_ttl_in;
         status.sum  = sum_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff   <= '0;
         header_words_ff <= '0;
         held_ttl_ff     <= '0;
         held_dest_ff    <= '0;
         running_sum_ff  <= '0;
      end else begin
         word_index_ff   <= word_index_in;
         header_words_ff <= header_words_in;
         held_ttl_ff     <= held_ttl_in;
         held_dest_ff    <= held_dest_in;
         running_sum_ff  <= running_sum_in;
      end
   end

endmodule

[design/ipv4fd_route_table.sv]
module ipv4fd_route_table #(
   parameter int ROUTE_ENTRIES = ipv4fd_pkg::ROUTE_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ipv4fd_pkg::route_add_type         add,
   output logic                              add_full,
   input  logic [ipv4fd_pkg::ADDR_W-1:0]     lookup_dest,
   output logic                              lookup_hit,
   output logic [ipv4fd_pkg::HOP_W-1:0]      lookup_hop
);

   localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

   logic [ipv4fd_pkg::ADDR_W-1:0] dest_ff [ROUTE_ENTRIES];
   logic [ipv4fd_pkg::HOP_W-1:0]  hop_mem [ROUTE_ENTRIES];
   logic [ROUTE_ENTRIES-1:0]      valid_ff;
   logic [ipv4fd_pkg::HOP_W-1:0]  hop_rd_ff;

   logic [ROUTE_ENTRIES-1:0]      add_match;
   logic [ROUTE_ENTRIES-1:0]      add_sel;
   logic [ROUTE_ENTRIES-1:0]      add_onehot;
   logic [ROUTE_ENTRIES-1:0]      look_match;
   logic [IDX_W-1:0]              add_idx;
   logic [IDX_W-1:0]              look_idx;
   logic                          add_write;

   // Compare every entry against both keys in parallel
   always_comb begin
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
         add_match[i]  = valid_ff[i] && (dest_ff[i] == add.dest);
         look_match[i] = valid_ff[i] && (dest_ff[i] == lookup_dest);
      end
   end

   // Pick the matching entry, else the lowest free one
   always_comb begin
      add_sel    = (|add_match) ? add_match : ~valid_ff;
      add_onehot = add_sel & (~add_sel + 1'b1);
      add_full   = ~(|add_sel);
      add_write  = add.en && !add_full;
      add_idx    = '0;
      look_idx   = '0;
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
         if (add_onehot[i]) add_idx = add_idx | IDX_W'(i);
         if (look_match[i]) look_idx = look_idx | IDX_W'(i);
      end
      lookup_hit = |look_match;
   end

   // Write destination cells
   always_ff @(posedge clock) begin
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
         if (add_write && add_onehot[i]) dest_ff[i] <= add.dest;
      end
   end

   // Mark entries valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (add_write) begin
         valid_ff <= valid_ff | add_onehot;
      end
   end

   // Next hop memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (add_write) hop_mem[add_idx] <= add.hop;
      hop_rd_ff <= hop_mem[look_idx];
   end

   assign lookup_hop = hop_rd_ff;

endmodule

[design/ipv4_forward_decision.sv]
// IPv4 forwarding decision. Each transfer on start is either a route addition or one 16-bit
// header word; busy is always low, so one item is taken in every cycle. The route table is
// updated at the edge after the accepting edge and an item that follows already sees it.
// A result (route added, table full, or the verdict at the last header word) passes through
// the input, decision and result registers to the rsp_ ports, marked by rsp_valid for exactly one cycle;
// the receiver cannot stall it and must take it then. Route lookup is an exact-match
// parallel compare across all entries; the next hop comes from a registered memory read.
module ipv4_forward_decision #(
   parameter int ROUTE_ENTRIES = ipv4fd_pkg::ROUTE_ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic [ipv4fd_pkg::ADDR_W-1:0]       req_route_dest,
   input  logic [ipv4fd_pkg::HOP_W-1:0]        req_route_next_hop,
   input  logic [ipv4fd_pkg::WORD_W-1:0]       req_header_word,
   input  logic                                csr_we,
   input  logic [ipv4fd_pkg::ADDR_W-1:0]       csr_wdata,
   output logic                                rsp_valid,
   output logic [ipv4fd_pkg::VERDICT_W-1:0]    rsp_verdict,
   output logic [ipv4fd_pkg::HOP_W-1:0]        rsp_next_hop,
   output logic [ipv4fd_pkg::TTL_W-1:0]        rsp_new_ttl,
   output logic [ipv4fd_pkg::WORD_W-1:0]       rsp_new_checksum
);

   // Configuration
   logic [ipv4fd_pkg::ADDR_W-1:0] local_addr_ff;

   // Input register
   logic                          s1_valid_ff;
   logic                          s1_cmd_ff;
   logic [ipv4fd_pkg::ADDR_W-1:0] s1_dest_ff;
   logic [ipv4fd_pkg::HOP_W-1:0]  s1_hop_ff;
   logic [ipv4fd_pkg::WORD_W-1:0] s1_word_ff;

   // Decision stage
   logic                          s2_valid_ff, s2_valid_in;
   logic                          s2_decide_ff, s2_decide_in;
   ipv4fd_pkg::verdict_type       s2_verdict_ff, s2_verdict_in;
   logic [ipv4fd_pkg::ADDR_W-1:0] s2_dest_ff;
   logic [ipv4fd_pkg::TTL_W-1:0]  s2_ttl_ff;
   logic [ipv4fd_pkg::SUM_W-1:0]  s2_sum_ff;

   // Result register
   logic                          rsp_valid_ff;
   ipv4fd_pkg::verdict_type       rsp_verdict_ff, rsp_verdict_in;
   logic                          rsp_fwd_ff;
   logic [ipv4fd_pkg::TTL_W-1:0]  rsp_ttl_ff, rsp_ttl_in;
   logic [ipv4fd_pkg::WORD_W-1:0] rsp_cks_ff, rsp_cks_in;

   ipv4fd_pkg::route_add_type     add;
   ipv4fd_pkg::hdr_status_type    hdr;
   logic                          add_full;
   logic                          lookup_hit;
   logic [ipv4fd_pkg::HOP_W-1:0]  lookup_hop;
   logic [16:0]                   fold1;
   logic [16:0]                   fold2;

   assign busy = 1'b0;

   // Hold the local address
   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
      end else if (csr_we) begin
         local_addr_ff <= csr_wdata;
      end
   end

   // Capture each accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_cmd_ff  <= req_cmd;
      s1_dest_ff <= req_route_dest;
      s1_hop_ff  <= req_route_next_hop;
      s1_word_ff <= req_header_word;
   end

   assign add.en   = s1_valid_ff && (s1_cmd_ff == ipv4fd_pkg::CMD_ADD_ROUTE);
   assign add.dest = s1_dest_ff;
   assign add.hop  = s1_hop_ff;

   ipv4fd_header_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .word_en (s1_valid_ff && (s1_cmd_ff == ipv4fd_pkg::CMD_HEADER_WORD)),
      .word    (s1_word_ff),
      .status  (hdr)
   );

   ipv4fd_route_table #(
      .ROUTE_ENTRIES (ROUTE_ENTRIES)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .add         (add),
      .add_full    (add_full),
      .lookup_dest (s2_dest_ff),
      .lookup_hit  (lookup_hit),
      .lookup_hop  (lookup_hop)
   );

   // Advance route results and finished headers to the decision stage
   always_comb begin
      s2_valid_in   = add.en || hdr.last;
      s2_decide_in  = hdr.last;
      s2_verdict_in = add_full ? ipv4fd_pkg::VERDICT_FULL : ipv4fd_pkg::VERDICT_ADDED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      s2_decide_ff  <= s2_decide_in;
      s2_verdict_ff <= s2_verdict_in;
      s2_dest_ff    <= hdr.dest;
      s2_ttl_ff     <= hdr.ttl;
      s2_sum_ff     <= hdr.sum;
   end

   // Fold the sum end-around and pick the verdict by priority
   always_comb begin
      fold1          = {1'b0, s2_sum_ff[15:0]} + 17'(s2_sum_ff[20:16]);
      fold2          = {1'b0, fold1[15:0]} + 17'(fold1[16]);
      rsp_verdict_in = s2_verdict_ff;
      if (s2_decide_ff) begin
         if (s2_dest_ff == local_addr_ff) begin
            rsp_verdict_in = ipv4fd_pkg::VERDICT_LOCAL;
         end else if (!lookup_hit) begin
            rsp_verdict_in = ipv4fd_pkg::VERDICT_NO_ROUTE;
         end else if (s2_ttl_ff == '0) begin
            rsp_verdict_in = ipv4fd_pkg::VERDICT_TTL_ZERO;
         end else begin
            rsp_verdict_in = ipv4fd_pkg::VERDICT_FORWARD;
         end
      end
      rsp_ttl_in = '0;
      rsp_cks_in = '0;
      if (rsp_verdict_in == ipv4fd_pkg::VERDICT_FORWARD) begin
         rsp_ttl_in = s2_ttl_ff - 8'd1;
         rsp_cks_in = ~fold2[15:0];
      end
   end

   // Drive the result for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_fwd_ff     <= (rsp_verdict_in == ipv4fd_pkg::VERDICT_FORWARD);
      rsp_ttl_ff     <= rsp_ttl_in;
      rsp_cks_ff     <= rsp_cks_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_next_hop     = rsp_fwd_ff ? lookup_hop : '0;
   assign rsp_new_ttl      = rsp_ttl_ff;
   assign rsp_new_checksum = rsp_cks_ff;

endmodule

[dv/tb_ipv4_forward_decision.sv]
module tb_ipv4_forward_decision;
   import ipv4fd_pkg::*;

   localparam int ROUTE_ENTRIES = ROUTE_ENTRIES_DEFAULT;
   localparam int CYCLE_LIMIT   = 100000;
   localparam int PHASE_ITEMS   = 232;

   typedef struct {
      logic              cmd;
      logic [ADDR_W-1:0] dest;
      logic [HOP_W-1:0]  hop;
      logic [WORD_W-1:0] word;
   } route_item_type;

   typedef struct {
      verdict_type       verdict;
      logic [HOP_W-1:0]  next_hop;
      logic [TTL_W-1:0]  new_ttl;
      logic [WORD_W-1:0] new_checksum;
   } decision_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_cmd = CMD_ADD_ROUTE;
   logic [ADDR_W-1:0]    req_route_dest = '0;
   logic [HOP_W-1:0]     req_route_next_hop = '0;
   logic [WORD_W-1:0]    req_header_word = '0;
   logic                 csr_we = 1'b0;
   logic [ADDR_W-1:0]    csr_wdata = '0;
   logic                 rsp_valid;
   logic [VERDICT_W-1:0] rsp_verdict;
   logic [HOP_W-1:0]     rsp_next_hop;
   logic [TTL_W-1:0]     rsp_new_ttl;
   logic [WORD_W-1:0]    rsp_new_checksum;

   // Items waiting to be sent and decisions waiting to be seen
   route_item_type pending_items[$];
   decision_type   decision_q[$];
   logic [ADDR_W-1:0] known_dests[$];

   // Shadow copy of the forwarding state
   logic [ADDR_W-1:0] tbl_dest [ROUTE_ENTRIES];
   logic [HOP_W-1:0]  tbl_hop [ROUTE_ENTRIES];
   bit                tbl_valid [ROUTE_ENTRIES];
   logic [WORD_IDX_W-1:0] hdr_pos = '0;
   logic [IHL_W-1:0]      hdr_len = '0;
   logic [TTL_W-1:0]      cap_ttl = '0;
   logic [ADDR_W-1:0]     cap_dest = '0;
   logic [SUM_W-1:0]      hdr_sum = '0;
   logic [ADDR_W-1:0]     cfg_local = '0;

   int err_count = 0;
   int cycle_count = 0;

   ipv4_forward_decision #(
      .ROUTE_ENTRIES(ROUTE_ENTRIES)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_route_dest    (req_route_dest),
      .req_route_next_hop(req_route_next_hop),
      .req_header_word   (req_header_word),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_verdict       (rsp_verdict),
      .rsp_next_hop      (rsp_next_hop),
      .rsp_new_ttl       (rsp_new_ttl),
      .rsp_new_checksum  (rsp_new_checksum)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Exact-match search over valid entries; -1 when nothing matches
   function automatic int lookup_route(input logic [ADDR_W-1:0] dest);
      int slot;
      slot = -1;
      for (int i = ROUTE_ENTRIES - 1; i >= 0; i--) begin
         if (tbl_valid[i] && tbl_dest[i] == dest) slot = i;
      end
      return slot;
   endfunction

   // Advance the shadow state by one item; return 1 when a decision is due
   function automatic bit forward_decide(input route_item_type it, output decision_type res);
      int slot;
      logic [WORD_W-1:0]     addend;
      logic [WORD_IDX_W-1:0] last_pos;
      logic [SUM_W-1:0]      folded;
      res.verdict      = VERDICT_LOCAL;
      res.next_hop     = '0;
      res.new_ttl      = '0;
      res.new_checksum = '0;
      if (it.cmd == CMD_ADD_ROUTE) begin
         slot = lookup_route(it.dest);
         if (slot < 0) begin
            for (int i = ROUTE_ENTRIES - 1; i >= 0; i--) begin
               if (!tbl_valid[i]) slot = i;
            end
         end
         if (slot < 0) begin
            res.verdict = VERDICT_FULL;
         end else begin
            tbl_dest[slot]  = it.dest;
            tbl_hop[slot]   = it.hop;
            tbl_valid[slot] = 1'b1;
            res.verdict     = VERDICT_ADDED;
         end
         return 1'b1;
      end

      addend = it.word;
      if (hdr_pos == WORD_IHL) begin
         hdr_len = (it.word[11:8] < MIN_IHL) ? MIN_IHL : it.word[11:8];
         hdr_sum = '0;
      end
      case (hdr_pos)
         WORD_TTL: begin
            cap_ttl = it.word[15:8];
            addend  = {cap_ttl - 8'd1, it.word[7:0]};
         end
         WORD_CHECKSUM: addend = '0;
         WORD_DEST_HI:  cap_dest[31:16] = it.word;
         WORD_DEST_LO:  cap_dest[15:0] = it.word;
         default: ;
      endcase
      hdr_sum  = hdr_sum + SUM_W'(addend);
      last_pos = {hdr_len, 1'b0} - 5'd1;
      if (hdr_pos < last_pos) begin
         hdr_pos = hdr_pos + 5'd1;
         return 1'b0;
      end

      // Close the header: end-around fold and pick the verdict by priority
      hdr_pos = '0;
      folded  = SUM_W'(hdr_sum[15:0]) + (hdr_sum >> 16);
      folded  = SUM_W'(folded[15:0]) + (folded >> 16);
      hdr_sum = '0;
      slot    = lookup_route(cap_dest);
      if (cap_dest == cfg_local) begin
         res.verdict = VERDICT_LOCAL;
      end else if (slot < 0) begin
         res.verdict = VERDICT_NO_ROUTE;
      end else if (cap_ttl == 8'd0) begin
         res.verdict = VERDICT_TTL_ZERO;
      end else begin
         res.verdict      = VERDICT_FORWARD;
         res.next_hop     = tbl_hop[slot];
         res.new_ttl      = cap_ttl - 8'd1;
         res.new_checksum = ~folded[15:0];
      end
      return 1'b1;
   endfunction

   function automatic bit is_known(input logic [ADDR_W-1:0] dest);
      foreach (known_dests[i]) begin
         if (known_dests[i] == dest) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Mostly fresh destinations, some replacements of routes already added
   function automatic logic [ADDR_W-1:0] pick_route_dest();
      if (known_dests.size() > 0 && $urandom_range(0, 99) < 30)
         return known_dests[$urandom_range(0, known_dests.size() - 1)];
      return $urandom();
   endfunction

   task automatic push_route(input logic [ADDR_W-1:0] dest, input logic [HOP_W-1:0] hop);
      route_item_type it;
      it.cmd  = CMD_ADD_ROUTE;
      it.dest = dest;
      it.hop  = hop;
      it.word = WORD_W'($urandom());
      pending_items.push_back(it);
      if (!is_known(dest) && known_dests.size() < ROUTE_ENTRIES) known_dests.push_back(dest);
   endtask

   task automatic push_word(input logic [WORD_W-1:0] w);
      route_item_type it;
      it.cmd  = CMD_HEADER_WORD;
      it.dest = $urandom();
      it.hop  = $urandom();
      it.word = w;
      pending_items.push_back(it);
   endtask

   // Queue one whole header; optionally slip a route addition in after word add_at
   task automatic push_header(input logic [IHL_W-1:0] ihl, input logic [TTL_W-1:0] ttl,
                              input logic [ADDR_W-1:0] dest, input int add_at);
      int n_words;
      logic [WORD_W-1:0] w;
      n_words = (ihl < MIN_IHL) ? 2 * int'(MIN_IHL) : 2 * int'(ihl);
      for (int i = 0; i < n_words; i++) begin
         w = WORD_W'($urandom());
         case (WORD_IDX_W'(i))
            WORD_IHL: begin
               w[11:8] = ihl;
               if ($urandom_range(0, 1)) w[15:12] = 4'h4;
            end
            WORD_TTL:     w[15:8] = ttl;
            WORD_DEST_HI: w = dest[31:16];
            WORD_DEST_LO: w = dest[15:0];
            default: ;
         endcase
         push_word(w);
         if (i == add_at) push_route(pick_route_dest(), $urandom());
      end
   endtask

   task automatic write_local(input logic [ADDR_W-1:0] addr);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= addr;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_local = addr;
   endtask

   // Wait for every transfer and decision, then let the pipeline settle
   task automatic wait_drained();
      while (pending_items.size() != 0 || start) @(posedge clock);
      while (decision_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random_phase(input logic [ADDR_W-1:0] addr);
      int r;
      int n_routes;
      logic [IHL_W-1:0]  ihl;
      logic [TTL_W-1:0]  ttl;
      logic [ADDR_W-1:0] dest;
      write_local(addr);
      while (pending_items.size() < PHASE_ITEMS) begin
         if ($urandom_range(0, 99) < 30) begin
            n_routes = $urandom_range(1, 10);
            repeat (n_routes) push_route(pick_route_dest(), $urandom());
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70)      ihl = MIN_IHL;
            else if (r < 85) ihl = IHL_W'($urandom_range(6, 15));
            else             ihl = IHL_W'($urandom_range(0, 4));
            r = $urandom_range(0, 99);
            if (r < 10)      ttl = 8'd0;
            else if (r < 20) ttl = 8'd1;
            else if (r < 30) ttl = 8'hff;
            else             ttl = $urandom();
            r = $urandom_range(0, 99);
            if (r < 55 && known_dests.size() > 0)
               dest = known_dests[$urandom_range(0, known_dests.size() - 1)];
            else if (r < 70)
               dest = cfg_local;
            else
               dest = $urandom();
            push_header(ihl, ttl, dest, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : -1);
         end
      end
      wait_drained();
   endtask

   // Driver: send queued items in bursts with random gaps between them
   int burst_left = 0;
   int gap_left = 0;
   route_item_type cur_item;

   always @(posedge clock) begin : driver
      decision_type d;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            if (forward_decide(cur_item, d)) decision_q.push_back(d);
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_items.size() > 0) begin
               cur_item = pending_items.pop_front();
               start              <= 1'b1;
               req_cmd            <= cur_item.cmd;
               req_route_dest     <= cur_item.dest;
               req_route_next_hop <= cur_item.hop;
               req_header_word    <= cur_item.word;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                           : $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
         err_count++;
      end
   endtask

   // Monitor: compare each result strobe against the oldest expected decision
   always @(posedge clock) begin : monitor
      decision_type want;
      if (!reset && rsp_valid) begin
         if (decision_q.size() == 0) begin
            $display("%0t: unexpected result, verdict %0d", $time, rsp_verdict);
            err_count++;
         end else begin
            want = decision_q.pop_front();
            check_field("verdict", 32'(want.verdict), 32'(rsp_verdict));
            check_field("next_hop", want.next_hop, rsp_next_hop);
            check_field("new_ttl", 32'(want.new_ttl), 32'(rsp_new_ttl));
            check_field("new_checksum", 32'(want.new_checksum), 32'(rsp_new_checksum));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme routes, next hop replacement, short IHL with TTL 1 and a
      // route added mid-header, then a local address that wins over TTL zero
      write_local(32'hC0A8_0001);
      push_route(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_route(32'h0000_0000, 32'h0000_0000);
      push_route(32'h0A00_0002, 32'h1234_5678);
      push_route(32'h0A00_0002, 32'h9ABC_DEF0);
      push_header(4'd0, 8'd1, 32'h0A00_0002, 3);
      push_header(MIN_IHL, 8'd0, 32'hC0A8_0001, -1);
      wait_drained();

      // Random phases over extreme and random local addresses
      run_random_phase(32'h0000_0000);
      run_random_phase(32'hFFFF_FFFF);
      run_random_phase($urandom());
      run_random_phase($urandom());

      repeat (10) @(posedge clock);
      if (err_count == 0 && decision_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
